### design/tss_pkg.sv
package tss_pkg;

    localparam int MaxExpertsDefault = 64;
    localparam int MaxSelectDefault  = 8;
    localparam int ScoreWidth        = 16;
    localparam int RowLenWidth       = 7;
    localparam int SelCountWidth     = 4;
    localparam int RankWidth         = 3;
    localparam logic [15:0] NegInfBits = 16'hFC00;

    localparam logic CfgRowLength   = 1'b0;
    localparam logic CfgSelectCount = 1'b1;

    // Order key of a half: sign-magnitude turned into two's complement.
    function automatic logic signed [16:0] half_key(input logic [15:0] h);
        logic signed [16:0] mag;
        mag = {2'b00, h[14:0]};
        half_key = h[15] ? -mag : mag;
    endfunction

    // A score may be chosen unless it is NaN or negative infinity.
    function automatic logic half_usable(input logic [15:0] h);
        half_usable = (h[14:0] <= 15'h7C00) && (h != NegInfBits);
    endfunction

endpackage

### design/tss_cell.sv
module tss_cell
    import tss_pkg::*;
#(
    parameter int IndexWidth = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear,
    input  logic                  ins_valid,
    input  logic [15:0]           ins_value,
    input  logic [IndexWidth-1:0] ins_index,
    input  logic                  left_beaten,
    input  logic [15:0]           left_value,
    input  logic [IndexWidth-1:0] left_index,
    output logic                  beaten,
    output logic [15:0]           value,
    output logic [IndexWidth-1:0] index
);

    logic [15:0]           value_reg;
    logic [IndexWidth-1:0] index_reg;

    // A new score beats this slot only when strictly greater.
    assign beaten = ins_valid && (half_key(ins_value) > half_key(value_reg));
    assign value  = value_reg;
    assign index  = index_reg;

    // Take the new score, take the left neighbor's entry, or hold.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            value_reg <= NegInfBits;
            index_reg <= '0;
        end else if (beaten && !left_beaten) begin
            value_reg <= ins_value;
            index_reg <= ins_index;
        end else if (beaten) begin
            value_reg <= left_value;
            index_reg <= left_index;
        end
    end

endmodule

### design/topk_score_selector_unit.sv
// Top-k score selector.
// The slave channel takes one fp16 score per word; tdata holds the score.
// Each score is inserted into a chain of slot cells that keeps the largest
// scores of the row in descending order; ties keep the earlier position.
// After the last score of a row the first select_count slots are copied into
// an output bank and sent on the master channel, one result per word, rank
// 0 first, tlast on the final one. Scores are accepted one per cycle,
// including the cycle that ends a row, as long as the output bank is free
// or hands its final word to the master in that same cycle.
// The first result appears in the cycle after the row's last score; a row
// sends select_count result words, so rows shorter than select_count stall input.
// A stalled master holds its word; the chain keeps filling the next row and
// only blocks on that row's last score until the bank drains.
// Reset (aresetn low, synchronous) clears all slots to -inf with position 0,
// the position counter and the read-out state (not the bank contents), and sets row_length 64,
// select_count 2. Configuration writes take effect the next cycle.
module topk_score_selector_unit
    import tss_pkg::*;
#(
    parameter int MAX_EXPERTS = MaxExpertsDefault,
    parameter int MAX_SELECT  = MaxSelectDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // score[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // top_value[15:0], expert_index[21:16], rank[24:22], 0
    output logic        m_tlast,   // final_of_row
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int IdxW = $clog2(MAX_EXPERTS);
    localparam int PosW = $clog2(MAX_EXPERTS + 1);
    localparam int SelW = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;

    logic [RowLenWidth-1:0]   row_length_reg;
    logic [SelCountWidth-1:0] select_count_reg;
    logic [PosW-1:0]          pos_reg;
    logic [PosW-1:0]          len_eff;
    logic [SelW-1:0]          cnt_last;
    logic                     accept, row_end, ins_valid;

    logic [MAX_SELECT-1:0] beaten;
    logic [15:0]           cval [MAX_SELECT];
    logic [IdxW-1:0]       cidx [MAX_SELECT];

    logic [15:0]     bval_reg [MAX_SELECT];
    logic [IdxW-1:0] bidx_reg [MAX_SELECT];
    logic            busy_reg;
    logic [SelW-1:0] rd_reg;
    logic [SelW-1:0] last_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg   <= RowLenWidth'(64);
            select_count_reg <= SelCountWidth'(2);
        end else if (cfg_we) begin
            if (cfg_index == CfgRowLength) row_length_reg <= cfg_data;
            else select_count_reg <= cfg_data[SelCountWidth-1:0];
        end
    end

    // Clamp the registers into their usable ranges.
    always_comb begin
        if (row_length_reg == '0) len_eff = PosW'(1);
        else if (32'(row_length_reg) > MAX_EXPERTS) len_eff = PosW'(MAX_EXPERTS);
        else len_eff = PosW'(row_length_reg);
        if (select_count_reg == '0) cnt_last = '0;
        else if (32'(select_count_reg) > MAX_SELECT) cnt_last = SelW'(MAX_SELECT - 1);
        else cnt_last = SelW'(select_count_reg - 1'b1);
    end

    // A row end waits only while the bank still holds words after this cycle.
    assign row_end   = (32'(pos_reg) + 1) >= 32'(len_eff);
    assign s_tready  = !(row_end && busy_reg && !(m_tready && (rd_reg == last_reg)));
    assign accept    = s_tvalid && s_tready;
    assign ins_valid = accept && half_usable(s_tdata);

    // Position counter within the row.
    always_ff @(posedge aclk) begin
        if (!aresetn) pos_reg <= '0;
        else if (accept) pos_reg <= row_end ? '0 : pos_reg + 1'b1;
    end

    // The slot chain; the first cell's left neighbor is never beaten.
    for (genvar g = 0; g < MAX_SELECT; g++) begin : g_cell
        tss_cell #(.IndexWidth(IdxW)) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .clear       (accept && row_end),
            .ins_valid   (ins_valid),
            .ins_value   (s_tdata),
            .ins_index   (pos_reg[IdxW-1:0]),
            .left_beaten ((g == 0) ? 1'b0 : beaten[(g == 0) ? 0 : g-1]),
            .left_value  (cval[(g == 0) ? 0 : g-1]),
            .left_index  (cidx[(g == 0) ? 0 : g-1]),
            .beaten      (beaten[g]),
            .value       (cval[g]),
            .index       (cidx[g])
        );
    end

    // Output bank: the final list of a row, including the last score.
    for (genvar g = 0; g < MAX_SELECT; g++) begin : g_bank
        always_ff @(posedge aclk) begin
            if (accept && row_end) begin
                if (beaten[g] && (g == 0 || !beaten[(g == 0) ? 0 : g-1])) begin
                    bval_reg[g] <= s_tdata;
                    bidx_reg[g] <= pos_reg[IdxW-1:0];
                end else if (beaten[g]) begin
                    bval_reg[g] <= cval[(g == 0) ? 0 : g-1];
                    bidx_reg[g] <= cidx[(g == 0) ? 0 : g-1];
                end else begin
                    bval_reg[g] <= cval[g];
                    bidx_reg[g] <= cidx[g];
                end
            end
        end
    end

    // Read-out sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rd_reg   <= '0;
            last_reg <= '0;
        end else if (accept && row_end) begin
            busy_reg <= 1'b1;
            rd_reg   <= '0;
            last_reg <= cnt_last;
        end else if (busy_reg && m_tready) begin
            if (rd_reg == last_reg) busy_reg <= 1'b0;
            rd_reg <= rd_reg + 1'b1;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = (rd_reg == last_reg);
    assign m_tdata  = {7'd0, RankWidth'(rd_reg),
                       6'(bidx_reg[rd_reg]), bval_reg[rd_reg]};

endmodule

### design/tss_checker.sv
module tss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // A row starts at rank zero after a final word.
    a_rank0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast ##1 m_tvalid |-> m_tdata[24:22] == 3'd0)
        else $error("new row does not start at rank zero");

    // Ranks count up within a row.
    a_rank_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tdata[24:22] == $past(m_tdata[24:22]) + 3'd1)
        else $error("rank did not advance");

    // Padding bits stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:25] == 7'd0)
        else $error("padding bits set");

    // Input is held back only while results are waiting to go out.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind topk_score_selector_unit tss_checker u_tss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
